// ----- hdl/ste_pkg.sv -----
// Shared definitions for the slice table engine: request and status codes,
// table entry layout, and the command and status bundles between the controller
// and the datapath. This package has no dependencies.
`default_nettype none

package ste_pkg;

   // Default table depth.
   localparam int MAX_SLICES_DEF = 16;

   // Field widths fixed by the request and response formats.
   localparam int ACT_W    = 3;
   localparam int KEY_W    = 32;
   localparam int SHARE_W  = 7;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int EIDX_W   = 4;

   // A full share, in percent.
   localparam logic [SHARE_W-1:0] FULL_SHARE = 7'd100;

   // Request action codes.
   localparam logic [ACT_W-1:0] ACT_ADD            = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE         = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR          = 3'd2;
   localparam logic [ACT_W-1:0] ACT_LOOKUP         = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LC_MATCH       = 3'd4;
   localparam logic [ACT_W-1:0] ACT_ENSURE_DEFAULT = 3'd5;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   // One table entry as held in the slice memory.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SHARE_W-1:0] share;
      logic               params;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // latch the request and reset the scan
      logic scan_issue;  // read the entry at the scan pointer
      logic rd_last;     // read the last entry of the table
      logic move;        // write the last entry into the removed slot
      logic commit;      // update the table and load the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             count_zero;
      logic             scan_last;
      logic             found;
      logic             found_is_last;
      logic             rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/ste_ctrl.sv -----
// Controller for the slice table engine: sequences the table scan, the
// remove move and the commit of each request. Depends on ste_pkg.
`default_nettype none

module ste_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire ste_pkg::sts_type sts,
   output ste_pkg::cmd_type cmd
);
   import ste_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_SCAN     = 8'b0000_0100,
      S_DRAIN    = 8'b0000_1000,
      S_DECIDE   = 8'b0001_0000,
      S_RDLAST   = 8'b0010_0000,
      S_MOVE     = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      needs_scan;

   // Clear, and the unused codes, finish without looking at the table.
   assign needs_scan = !sts.count_zero &&
                       (sts.action == ACT_ADD || sts.action == ACT_REMOVE ||
                        sts.action == ACT_LOOKUP || sts.action == ACT_LC_MATCH ||
                        sts.action == ACT_ENSURE_DEFAULT);

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = needs_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.action == ACT_REMOVE && sts.found && !sts.found_is_last) begin
               state_in = S_RDLAST;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RDLAST: begin
            cmd.rd_last = 1'b1;
            state_in    = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.commit = 1'b1;
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ste_datapath.sv -----
// Datapath for the slice table engine: request registers, slice memory, scan
// compare and share sum, commit logic and response register. Depends on ste_pkg.
`default_nettype none

module ste_datapath #(
   parameter int MAX_SLICES = ste_pkg::MAX_SLICES_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  [ste_pkg::ACT_W-1:0]      req_action,
   input  wire  [ste_pkg::KEY_W-1:0]      req_key,
   input  wire  [ste_pkg::SHARE_W-1:0]    req_share,
   input  wire                            req_params,
   input  wire  [ste_pkg::POS_W-1:0]      req_pos,
   input  wire                            csr_wr_en,
   input  wire  [ste_pkg::SHARE_W-1:0]    csr_wr_data,
   input  wire  ste_pkg::cmd_type         cmd,
   output ste_pkg::sts_type               sts,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [ste_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ste_pkg::EIDX_W-1:0]     rsp_eidx,
   output logic                           rsp_matched,
   output logic [ste_pkg::SHARE_W-1:0]    rsp_share
);
   import ste_pkg::*;

   localparam int IDXW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int CNTW = $clog2(MAX_SLICES + 1);
   localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;
   localparam int SUMW = $clog2(MAX_SLICES * 127 + 1);

   // Request registers.
   logic [ACT_W-1:0]   action_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [SHARE_W-1:0] share_ff;
   logic               params_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [SHARE_W-1:0] floor_ff;

   // Table state.
   logic [CNTW-1:0]    count_ff, count_in;
   entry_type          mem [MAX_SLICES];
   entry_type          rd_data_ff;
   logic               rd_en;
   logic [IDXW-1:0]    rd_addr;
   logic               wr_en;
   logic [IDXW-1:0]    wr_addr;
   entry_type          wr_data;

   // Scan state.
   logic [IDXW-1:0]    scan_idx_ff;
   logic               rd_vld_ff;
   logic [IDXW-1:0]    rd_tag_ff;
   logic               found_ff;
   logic [IDXW-1:0]    found_idx_ff;
   logic [SUMW-1:0]    sum_ff;
   logic [KEY_W-1:0]   pos_key_ff;
   logic [IDXW-1:0]    last_idx;
   logic [CNTW-1:0]    count_m1;

   // Response register.
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic [EIDX_W-1:0]  rsp_eidx_ff, eidx_in;
   logic               rsp_matched_ff, matched_in;
   logic [SHARE_W-1:0] rsp_share_ff, share_in;
   logic               rsp_free;
   logic               do_commit;

   // Share calculation for the default slice.
   logic [SHARE_W-1:0] diff_share;
   logic [SHARE_W-1:0] floored_share;
   logic [SHARE_W-1:0] default_share;

   // Index conversions to a common compare width.
   logic [CMPW-1:0]    found_wide;
   logic [CMPW-1:0]    count_wide;
   logic [CMPW-1:0]    pos_wide;
   logic [CMPW-1:0]    tag_wide;

   assign count_m1   = count_ff - CNTW'(1);
   assign last_idx   = count_m1[IDXW-1:0];
   assign found_wide = CMPW'(found_idx_ff);
   assign count_wide = CMPW'(count_ff);
   assign pos_wide   = CMPW'(pos_ff);
   assign tag_wide   = CMPW'(rd_tag_ff);

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign do_commit = cmd.commit && rsp_free;

   // Status towards the controller.
   assign sts.action        = action_ff;
   assign sts.count_zero    = (count_ff == '0);
   assign sts.scan_last     = (scan_idx_ff == last_idx);
   assign sts.found         = found_ff;
   assign sts.found_is_last = (found_idx_ff == last_idx);
   assign sts.rsp_free      = rsp_free;

   // Request capture; ensure-default always works on the all-zero key.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         key_ff    <= (req_action == ACT_ENSURE_DEFAULT) ? '0 : req_key;
         share_ff  <= req_share;
         params_ff <= req_params;
         pos_ff    <= req_pos;
      end
   end

   // Share floor register.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
      end else if (csr_wr_en) begin
         floor_ff <= csr_wr_data;
      end
   end

   // Slice memory with one write port and a registered read port.
   assign rd_en   = cmd.scan_issue || cmd.rd_last;
   assign rd_addr = cmd.scan_issue ? scan_idx_ff : last_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Scan pointer and read tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_issue;
      end
      if (cmd.accept) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_idx_ff <= scan_idx_ff + IDXW'(1);
      end
      rd_tag_ff <= scan_idx_ff;
   end

   // Key compare, first-match capture, share sum and position key capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
         sum_ff       <= '0;
         pos_key_ff   <= '0;
      end else if (rd_vld_ff) begin
         if (!found_ff && rd_data_ff.key == key_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= rd_tag_ff;
         end
         if (rd_data_ff.key != '0 && rd_data_ff.params) begin
            sum_ff <= sum_ff + SUMW'(rd_data_ff.share);
         end
         if (tag_wide == pos_wide) begin
            pos_key_ff <= rd_data_ff.key;
         end
      end
   end

   // Default share: 100 minus the sum, raised to the floor, capped at 100.
   assign diff_share    = (sum_ff < SUMW'(FULL_SHARE)) ?
                          (FULL_SHARE - sum_ff[SHARE_W-1:0]) : '0;
   assign floored_share = (diff_share > floor_ff) ? diff_share : floor_ff;
   assign default_share = (floored_share > FULL_SHARE) ? FULL_SHARE : floored_share;

   // Commit: table write, count update and response fields.
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = found_idx_ff;
      wr_data    = rd_data_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      eidx_in    = '0;
      matched_in = 1'b0;
      share_in   = '0;
      if (cmd.move) begin
         wr_en = 1'b1;
      end
      case (action_ff)
         ACT_ADD, ACT_ENSURE_DEFAULT: begin
            wr_data.key    = key_ff;
            wr_data.share  = (action_ff == ACT_ADD) ? share_ff : default_share;
            wr_data.params = (action_ff == ACT_ADD) ? params_ff : 1'b1;
            if (action_ff == ACT_ENSURE_DEFAULT) begin
               share_in = default_share;
            end
            if (found_ff) begin
               wr_en   = do_commit;
               eidx_in = found_wide[EIDX_W-1:0];
            end else if (count_ff < CNTW'(MAX_SLICES)) begin
               wr_en   = do_commit;
               wr_addr = count_ff[IDXW-1:0];
               eidx_in = count_wide[EIDX_W-1:0];
               if (do_commit) begin
                  count_in = count_ff + CNTW'(1);
               end
            end else begin
               status_in = ST_FULL;
            end
         end
         ACT_REMOVE, ACT_LOOKUP: begin
            if (found_ff) begin
               eidx_in    = found_wide[EIDX_W-1:0];
               matched_in = 1'b1;
               if (action_ff == ACT_REMOVE && do_commit) begin
                  count_in = count_m1;
               end
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         ACT_CLEAR: begin
            if (do_commit) begin
               count_in = '0;
            end
         end
         ACT_LC_MATCH: begin
            eidx_in = pos_ff;
            if (pos_wide >= count_wide) begin
               status_in = ST_BAD_INDEX;
            end else if (pos_key_ff == key_ff) begin
               matched_in = 1'b1;
            end else if (pos_key_ff == '0 && !found_ff) begin
               matched_in = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register; it frees as soon as the response is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (do_commit) begin
         rsp_status_ff  <= status_in;
         rsp_eidx_ff    <= eidx_in;
         rsp_matched_ff <= matched_in;
         rsp_share_ff   <= share_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_eidx    = rsp_eidx_ff;
   assign rsp_matched = rsp_matched_ff;
   assign rsp_share   = rsp_share_ff;

   // The table never holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SLICES))
      else $error("entry count exceeds table depth");

   // The scan never reads beyond the valid entries.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> (scan_idx_ff < count_ff[IDXW-1:0] ||
                          CMPW'(scan_idx_ff) < count_wide))
      else $error("scan read beyond entry count");

   // A successful remove drops exactly one entry.
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      (do_commit && action_ff == ACT_REMOVE && found_ff) |=>
      (count_ff + CNTW'(1) == $past(count_ff)))
      else $error("remove did not decrement the entry count");

   // A clear empties the table.
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (do_commit && action_ff == ACT_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries in the table");

   // A committed response is never dropped while still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !do_commit)
      else $error("response overwritten before it was taken");

endmodule

`default_nettype wire

// ----- hdl/slice_table_engine_top.sv -----
// Top level of the slice table engine: unpacks the request stream, joins the
// controller and the datapath, and packs the response stream.
// Depends on ste_pkg, ste_ctrl and ste_datapath.
//
// A request scans the table unless it is a clear or an unused code or the
// table is empty; a remove that moves the last entry adds a read of the last
// entry and a write. A new request is taken only once the previous response
// is committed. The scan reads the slice memory one entry per cycle.
// Reset: synchronous, clears the entry count, the share floor, the controller
// and the response valid; the table memory is not cleared and needs no pass.
`default_nettype none

module slice_table_engine_top #(
   parameter int MAX_SLICES = ste_pkg::MAX_SLICES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // Request: key [31:0], share_value [38:32], has_params [39],
   // slice_index [43:40], zero [47:44].
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,
   // Request: action [2:0].
   input  wire  [2:0]  req_tuser,
   // Response: status [1:0], entry_index [5:2], matched [6], share_out [13:7],
   // zero [15:14].
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,
   // Share floor register.
   input  wire         csr_wr_en,
   input  wire  [6:0]  csr_wr_data
);
   import ste_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [STATUS_W-1:0] rsp_status;
   logic [EIDX_W-1:0]   rsp_eidx;
   logic                rsp_matched;
   logic [SHARE_W-1:0]  rsp_share;

   // Sequencer.
   ste_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Table and arithmetic.
   ste_datapath #(
      .MAX_SLICES (MAX_SLICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_action  (req_tuser),
      .req_key     (req_tdata[31:0]),
      .req_share   (req_tdata[38:32]),
      .req_params  (req_tdata[39]),
      .req_pos     (req_tdata[43:40]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_eidx    (rsp_eidx),
      .rsp_matched (rsp_matched),
      .rsp_share   (rsp_share)
   );

   // Response packing.
   assign rsp_tdata = {2'b00, rsp_share, rsp_matched, rsp_eidx, rsp_status};

endmodule

`default_nettype wire

// ----- test/slice_table_engine_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the slice table engine. It watches the request, response and
// share floor ports, predicts every response from its own copy of the slice table and
// compares field by field. Depends on ste_pkg.

module slice_table_engine_checker #(
   parameter int DEPTH = ste_pkg::MAX_SLICES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [47:0] req_tdata,
   input  wire  [2:0]  req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,
   input  wire         csr_wr_en,
   input  wire  [6:0]  csr_wr_data,
   output int          fail_count,
   output int          pending
);
   import ste_pkg::*;

   // One predicted response, one field per member.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [EIDX_W-1:0]   entry_index;
      logic                matched;
      logic [SHARE_W-1:0]  share_out;
   } slice_reply_type;

   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Shadow copy of the share floor and of the slice table.
   logic [SHARE_W-1:0] share_floor;
   logic [COUNT_W-1:0] slice_count;
   logic [KEY_W-1:0]   slice_key_mem   [DEPTH];
   logic [SHARE_W-1:0] slice_share_mem [DEPTH];
   logic               slice_param_mem [DEPTH];

   slice_reply_type    expected_replies [$];
   int                 reply_seq;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("response %0d: %s is %0d, expected %0d",
                                   reply_seq, name, got, want));
   endtask

   // Position of a key among the valid entries, or -1 when it is absent.
   function automatic int find_slice(input logic [KEY_W-1:0] key);
      for (int i = 0; i < int'(slice_count); i++)
         if (slice_key_mem[i] == key)
            return i;
      return -1;
   endfunction

   // Overwrites a matching entry or appends a new one; -1 when the table is full.
   function automatic int store_slice(input logic [KEY_W-1:0] key,
                                      input logic [SHARE_W-1:0] share,
                                      input logic flag);
      int slot;
      slot = find_slice(key);
      if (slot < 0) begin
         if (int'(slice_count) >= DEPTH)
            return -1;
         slot = int'(slice_count);
         slice_count++;
      end
      slice_key_mem[slot]   = key;
      slice_share_mem[slot] = share;
      slice_param_mem[slot] = flag;
      return slot;
   endfunction

   // Applies one request to the shadow table and returns the response it must cause.
   function automatic slice_reply_type predict_reply(input logic [ACT_W-1:0] act,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [SHARE_W-1:0] share,
                                                     input logic flag,
                                                     input logic [POS_W-1:0] pos);
      slice_reply_type reply;
      int slot;
      int last;
      int share_sum;
      int ratio;
      reply = '0;
      case (act)
         ACT_ADD: begin
            slot = store_slice(key, share, flag);
            if (slot < 0)
               reply.status = ST_FULL;
            else
               reply.entry_index = EIDX_W'(slot);
         end
         ACT_REMOVE: begin
            slot = find_slice(key);
            if (slot < 0) begin
               reply.status = ST_NOT_FOUND;
            end else begin
               // The last entry fills the hole left by the removed one.
               last = int'(slice_count) - 1;
               reply.entry_index = EIDX_W'(slot);
               reply.matched = 1'b1;
               if (slot != last) begin
                  slice_key_mem[slot]   = slice_key_mem[last];
                  slice_share_mem[slot] = slice_share_mem[last];
                  slice_param_mem[slot] = slice_param_mem[last];
               end
               slice_count--;
            end
         end
         ACT_CLEAR: begin
            slice_count = '0;
         end
         ACT_LOOKUP: begin
            slot = find_slice(key);
            if (slot < 0) begin
               reply.status = ST_NOT_FOUND;
            end else begin
               reply.entry_index = EIDX_W'(slot);
               reply.matched = 1'b1;
            end
         end
         ACT_LC_MATCH: begin
            // The default slice matches any key that the table does not hold.
            reply.entry_index = pos;
            if (int'(pos) >= int'(slice_count))
               reply.status = ST_BAD_INDEX;
            else if (slice_key_mem[pos] == key)
               reply.matched = 1'b1;
            else if (slice_key_mem[pos] == '0 && find_slice(key) < 0)
               reply.matched = 1'b1;
         end
         ACT_ENSURE_DEFAULT: begin
            share_sum = 0;
            for (int i = 0; i < int'(slice_count); i++)
               if (slice_key_mem[i] != '0 && slice_param_mem[i])
                  share_sum += int'(slice_share_mem[i]);
            ratio = int'(FULL_SHARE) - share_sum;
            if (ratio < int'(share_floor))
               ratio = int'(share_floor);
            if (ratio > int'(FULL_SHARE))
               ratio = int'(FULL_SHARE);
            reply.share_out = SHARE_W'(ratio);
            slot = store_slice('0, reply.share_out, 1'b1);
            if (slot < 0)
               reply.status = ST_FULL;
            else
               reply.entry_index = EIDX_W'(slot);
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   // Predict on every accepted request, compare on every accepted response.
   always @(posedge clock) begin : watch
      slice_reply_type want;
      if (reset) begin
         share_floor = '0;
         slice_count = '0;
         reply_seq = 0;
         fail_count = 0;
         expected_replies.delete();
      end else begin
         if (csr_wr_en)
            share_floor = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_replies.push_back(predict_reply(req_tuser, req_tdata[31:0],
                                                     req_tdata[38:32], req_tdata[39],
                                                     req_tdata[43:40]));
         if (rsp_tvalid && rsp_tready) begin
            reply_seq++;
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                         reply_seq));
            end else begin
               want = expected_replies.pop_front();
               check_field("status", int'(rsp_tdata[1:0]), int'(want.status));
               check_field("entry_index", int'(rsp_tdata[5:2]), int'(want.entry_index));
               check_field("matched", int'(rsp_tdata[6]), int'(want.matched));
               check_field("share_out", int'(rsp_tdata[13:7]), int'(want.share_out));
            end
         end
      end
      pending = expected_replies.size();
   end

endmodule

// ----- test/slice_table_engine_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the slice table engine: drives directed and random requests
// through phases of sender idling and receiver stalls and gives the verdict.
// Depends on ste_pkg, slice_table_engine_top and slice_table_engine_checker.

module slice_table_engine_top_test;
   import ste_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 212;
   localparam int POOL_SIZE      = 20;

   // Action codes that the block ignores.
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [15:0] rsp_tdata;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   int          fail_count;
   int          pending;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          items_sent;
   int          quiet_cycles;
   logic [31:0] key_pool [POOL_SIZE];

   slice_table_engine_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slice_table_engine_checker #(.DEPTH(MAX_SLICES_DEF)) table_watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, redrawn on every falling edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: too many cycles without a single request or response moving.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("slice_table_engine_top regression: fail");
            $finish;
         end
      end
   end

   // Presents one request, after a random idle gap, and waits until it is taken.
   task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [SHARE_W-1:0] share, input logic flag,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = act;
      req_tdata  = {4'b0000, pos, flag, share, key};
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      items_sent++;
   endtask

   // The floor is only written once every response has come back.
   task automatic write_floor(input logic [SHARE_W-1:0] floor_value);
      while (pending != 0)
         @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = floor_value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // One request with weighted action and keys mostly drawn from a small pool.
   task automatic random_request();
      int pick;
      logic [ACT_W-1:0] act;
      logic [KEY_W-1:0] key;
      logic [SHARE_W-1:0] share;
      pick = $urandom_range(99);
      if (pick < 40)
         act = ACT_ADD;
      else if (pick < 55)
         act = ACT_REMOVE;
      else if (pick < 68)
         act = ACT_LOOKUP;
      else if (pick < 83)
         act = ACT_LC_MATCH;
      else if (pick < 94)
         act = ACT_ENSURE_DEFAULT;
      else if (pick < 96)
         act = ACT_CLEAR;
      else
         act = ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
      if ($urandom_range(99) < 85)
         key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
         key = $urandom();
      pick = $urandom_range(99);
      if (pick < 10)
         share = '0;
      else if (pick < 20)
         share = FULL_SHARE;
      else if (pick < 50)
         share = SHARE_W'($urandom_range(15));
      else
         share = SHARE_W'($urandom_range(100));
      send_request(act, key, share, 1'($urandom_range(1)), POS_W'($urandom_range(15)));
   endtask

   // Fills the table from empty, hits the full cases, then frees one slot for the default.
   task automatic fill_table();
      logic [KEY_W-1:0] filled [MAX_SLICES_DEF];
      send_request(ACT_CLEAR, $urandom(), '0, 1'b0, '0);
      for (int i = 0; i < MAX_SLICES_DEF; i++) begin
         filled[i] = {8'(i + 1), 24'($urandom())};
         send_request(ACT_ADD, filled[i], SHARE_W'($urandom_range(12)),
                      1'($urandom_range(1)), '0);
      end
      send_request(ACT_ADD, {8'hFF, 24'($urandom())}, SHARE_W'($urandom_range(100)), 1'b1,
                   '0);
      send_request(ACT_ENSURE_DEFAULT, $urandom(), '0, 1'b0, '0);
      repeat (3)
         send_request(ACT_LC_MATCH, filled[$urandom_range(MAX_SLICES_DEF - 1)], '0, 1'b0,
                      POS_W'($urandom_range(15)));
      send_request(ACT_REMOVE, filled[$urandom_range(MAX_SLICES_DEF - 1)], '0, 1'b0, '0);
      send_request(ACT_ENSURE_DEFAULT, $urandom(), '0, 1'b0, '0);
      send_request(ACT_LC_MATCH, $urandom(), '0, 1'b0, 4'd15);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      key_pool[0]    = '0;
      key_pool[1]    = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the floor at its reset value of zero.
      send_request(ACT_LOOKUP, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      send_request(ACT_REMOVE, 32'h0100_0001, 7'd0, 1'b0, 4'd0);
      send_request(ACT_LC_MATCH, 32'h0100_0001, 7'd0, 1'b0, 4'd0);
      send_request(ACT_ENSURE_DEFAULT, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      send_request(ACT_ADD, 32'hFFFF_FFFF, 7'd100, 1'b1, 4'd0);
      send_request(ACT_ADD, 32'h0100_0001, 7'd0, 1'b1, 4'd0);
      // Modify in place; without params the share is stored but not summed.
      send_request(ACT_ADD, 32'h0100_0001, 7'd30, 1'b0, 4'd0);
      send_request(ACT_ENSURE_DEFAULT, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      // The default slot matches an absent key but not one held elsewhere.
      send_request(ACT_LC_MATCH, 32'h1234_5678, 7'd0, 1'b0, 4'd0);
      send_request(ACT_LC_MATCH, 32'hFFFF_FFFF, 7'd0, 1'b0, 4'd0);
      send_request(ACT_LC_MATCH, 32'hFFFF_FFFF, 7'd0, 1'b0, 4'd1);
      send_request(ACT_LC_MATCH, 32'h0100_0001, 7'd0, 1'b0, 4'd15);
      send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 7'd0, 1'b0, 4'd0);
      // Removing the first entry moves the last one into its slot.
      send_request(ACT_REMOVE, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      send_request(ACT_LOOKUP, 32'h0100_0001, 7'd0, 1'b0, 4'd0);
      send_request(ACT_REMOVE, 32'h0100_0001, 7'd0, 1'b0, 4'd0);
      send_request(ACT_REMOVE, 32'hFFFF_FFFF, 7'd0, 1'b0, 4'd0);
      send_request(ACT_SPARE_LO, 32'hA5A5_5A5A, 7'd85, 1'b1, 4'd9);
      send_request(ACT_SPARE_HI, 32'h5A5A_A5A5, 7'd42, 1'b0, 4'd6);
      send_request(ACT_ADD, 32'h0000_0000, 7'd100, 1'b0, 4'd0);
      send_request(ACT_ADD, 32'h7F00_FFFF, 7'd64, 1'b1, 4'd0);
      send_request(ACT_ENSURE_DEFAULT, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      send_request(ACT_CLEAR, 32'h0000_0000, 7'd0, 1'b0, 4'd0);
      send_request(ACT_LOOKUP, 32'h7F00_FFFF, 7'd0, 1'b0, 4'd0);

      // Random phases, each with its own floor and handshake pressure.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_floor(FULL_SHARE);
            1: write_floor(7'd127);
            2: write_floor(SHARE_W'($urandom_range(1, 99)));
            default: write_floor('0);
         endcase
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 88 : 26) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 88 : 26) : 0;
         items_sent = 0;
         if (phase == 0)
            fill_table();
         while (items_sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 5)
               fill_table();
            else
               random_request();
         end
      end

      // Drain the responses still in flight, then allow for the block's latency.
      while (pending != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("slice_table_engine_top regression: pass");
      else
         $display("slice_table_engine_top regression: fail");
      $finish;
   end

endmodule
